>>> sv/pfc_pkg.sv
// Package for the Playfair cipher engine: transaction payload types, the
// sequencer state type and the letter constants shared by the RTL and checker.
// No dependencies.
package pfc_pkg;

    localparam int unsigned LTR_W     = 5;
    localparam int unsigned NUM_LTRS  = 26;
    localparam int unsigned NUM_CELLS = 25;

    localparam logic [LTR_W-1:0] LTR_I    = 5'd8;
    localparam logic [LTR_W-1:0] LTR_J    = 5'd9;
    localparam logic [LTR_W-1:0] LTR_X    = 5'd23;
    localparam logic [LTR_W-1:0] LTR_Z    = 5'd25;
    localparam logic [LTR_W-1:0] CELL_CNT = 5'd25;

    localparam logic MODE_KEY = 1'b0;
    localparam logic MODE_MSG = 1'b1;
    localparam logic DIR_ENC  = 1'b0;
    localparam logic DIR_DEC  = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [LTR_W-1:0] letter;
        logic             last;
    } t_in_item;

    typedef struct packed {
        logic [LTR_W-1:0] out_letter;
        logic             last_of_run;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FILL,
        S_POS_A,
        S_POS_B,
        S_CALC,
        S_SQ_A,
        S_SQ_B,
        S_EMIT_P,
        S_EMIT_Q
    } t_state;

endpackage

>>> sv/pfc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Read data holds while the read enable is low. No dependencies.
module pfc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/playfair_cipher_engine.sv
// Playfair cipher engine, top level. Depends on pfc_pkg and pfc_ram.
// Sequence: a key letter is taken in the idle state; the final key letter adds a walk
// that fills the unused letters. A message letter that completes no pair is taken in
// the idle state; a pair adds two position reads, index arithmetic, two square reads
// and two emits, a padded tail pair adds them again, and output stalls hold the emits.
// The sequencer and the single read port of each memory set these steps.
// Reset: synchronous, active low; clears the used marks, counters and flags, not the RAMs.
module playfair_cipher_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pfc_pkg::t_in_item i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output pfc_pkg::t_out_item o_out,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata
);

    // Square index (0..24) to row and column, and back.
    function automatic logic [2:0] f_row(input logic [4:0] idx);
        logic [2:0] row;
        if (idx >= 5'd20) begin
            row = 3'd4;
        end else if (idx >= 5'd15) begin
            row = 3'd3;
        end else if (idx >= 5'd10) begin
            row = 3'd2;
        end else if (idx >= 5'd5) begin
            row = 3'd1;
        end else begin
            row = 3'd0;
        end
        return row;
    endfunction

    function automatic logic [4:0] f_base(input logic [2:0] row);
        return {row, 2'b00} + {2'b00, row};
    endfunction

    function automatic logic [2:0] f_col(input logic [4:0] idx);
        logic [4:0] diff;
        diff = idx - f_base(f_row(idx));
        return diff[2:0];
    endfunction

    // Step one place around the square: forwards to encrypt, backwards to decrypt.
    function automatic logic [2:0] f_step(input logic [2:0] v, input logic dec);
        logic [2:0] res;
        if (dec) begin
            res = (v == 3'd0) ? 3'd4 : v - 3'd1;
        end else begin
            res = (v == 3'd4) ? 3'd0 : v + 3'd1;
        end
        return res;
    endfunction

    function automatic logic [4:0] f_cell(input logic [2:0] row, input logic [2:0] col);
        return f_base(row) + {2'b00, col};
    endfunction

    // ---------------------------------------------------------------- registers
    pfc_pkg::t_state    r_state, n_state;
    logic [25:0]        r_used, n_used;       // used marks, one flop per letter
    logic [4:0]         r_fill, n_fill;       // next free square cell
    logic               r_key_done, n_key_done;
    logic [4:0]         r_pend, n_pend;       // pending message letter
    logic               r_pend_v, n_pend_v;
    logic               r_dir;                // configuration: direction
    logic [4:0]         r_walk, n_walk;       // alphabet walk after the last key letter
    logic [4:0]         r_a, n_a;             // current pair
    logic [4:0]         r_b, n_b;
    logic [4:0]         r_a2, n_a2;           // first letter of the padded tail pair
    logic               r_more, n_more;       // a tail pair follows this one
    logic [4:0]         r_ia, n_ia;           // square index of the first letter
    logic [4:0]         r_na, n_na;           // ciphered square indices
    logic [4:0]         r_nb, n_nb;
    logic [4:0]         r_p, n_p;             // first ciphered letter
    logic               r_out_valid, n_out_valid;
    pfc_pkg::t_out_item r_out, n_out;

    // ---------------------------------------------------------------- RAM ports
    logic       sq_we, sq_re, pos_we, pos_re;
    logic [4:0] sq_waddr, sq_wdata, sq_raddr, sq_rdata;
    logic [4:0] pos_waddr, pos_wdata, pos_raddr, pos_rdata;

    // square: cell -> letter; position: letter -> cell
    pfc_ram #(.WIDTH(5), .DEPTH(25)) u_square (
        .i_clk   (i_clk),
        .i_we    (sq_we),
        .i_waddr (sq_waddr),
        .i_wdata (sq_wdata),
        .i_re    (sq_re),
        .i_raddr (sq_raddr),
        .o_rdata (sq_rdata)
    );

    pfc_ram #(.WIDTH(5), .DEPTH(26)) u_position (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (pos_waddr),
        .i_wdata (pos_wdata),
        .i_re    (pos_re),
        .i_raddr (pos_raddr),
        .o_rdata (pos_rdata)
    );

    // ---------------------------------------------------------------- key placement
    logic        in_ok;
    logic [4:0]  in_ltr;
    logic [25:0] used_eff;
    logic [4:0]  fill_eff;
    logic [4:0]  place_ltr;
    logic [4:0]  place_fill;
    logic        place_ok;

    // Letters above z are ignored, though their last mark still acts.
    assign in_ok  = (i_in.letter <= pfc_pkg::LTR_Z);
    // In a message, read j as i.
    assign in_ltr = (in_ok && i_in.letter == pfc_pkg::LTR_J) ? pfc_pkg::LTR_I : i_in.letter;

    // A key letter after a complete key starts a fresh square.
    assign used_eff = r_key_done ? '0 : r_used;
    assign fill_eff = r_key_done ? '0 : r_fill;

    assign place_ltr  = (r_state == pfc_pkg::S_FILL) ? r_walk : i_in.letter;
    assign place_fill = (r_state == pfc_pkg::S_FILL) ? r_fill : fill_eff;

    always_comb begin
        if (r_state == pfc_pkg::S_FILL) begin
            place_ok = (r_walk != pfc_pkg::LTR_J) && !r_used[r_walk]
                       && (r_fill < pfc_pkg::CELL_CNT);
        end else begin
            place_ok = in_ok && (i_in.letter != pfc_pkg::LTR_J)
                       && (in_ok ? !used_eff[i_in.letter] : 1'b0)
                       && (fill_eff < pfc_pkg::CELL_CNT);
        end
    end

    assign sq_waddr  = place_fill;
    assign sq_wdata  = place_ltr;
    assign pos_waddr = place_ltr;
    assign pos_wdata = place_fill;

    // ---------------------------------------------------------------- message pairing
    logic       has_pair;
    logic [4:0] pair_b;
    logic       pend_v_mid;
    logic [4:0] pend_mid;
    logic       tail;

    assign has_pair = in_ok && r_pend_v;
    // Encrypting a doubled pair gives letter plus x and keeps the letter pending.
    assign pair_b   = (r_dir == pfc_pkg::DIR_ENC && r_pend == in_ltr) ? pfc_pkg::LTR_X
                                                                      : in_ltr;
    assign pend_v_mid = in_ok ? (!r_pend_v || (r_dir == pfc_pkg::DIR_ENC && r_pend == in_ltr))
                              : r_pend_v;
    assign pend_mid   = (in_ok && !r_pend_v) ? in_ltr : r_pend;
    // Encrypting pads an odd tail with x; decrypting just drops it.
    assign tail       = (r_dir == pfc_pkg::DIR_ENC) && i_in.last && pend_v_mid;

    // ---------------------------------------------------------------- pair arithmetic
    logic [2:0] ra, ca, rb, cb;
    logic [4:0] calc_na, calc_nb;

    assign ra = f_row(r_ia);
    assign ca = f_col(r_ia);
    assign rb = f_row(pos_rdata);
    assign cb = f_col(pos_rdata);

    always_comb begin
        if (ra == rb) begin
            calc_na = f_cell(ra, f_step(ca, r_dir));
            calc_nb = f_cell(rb, f_step(cb, r_dir));
        end else if (ca == cb) begin
            calc_na = f_cell(f_step(ra, r_dir), ca);
            calc_nb = f_cell(f_step(rb, r_dir), cb);
        end else begin
            // rectangle: swap columns
            calc_na = f_cell(ra, cb);
            calc_nb = f_cell(rb, ca);
        end
    end

    // ---------------------------------------------------------------- output side
    logic slot_free;
    logic drop_p, drop_q;

    assign slot_free = !r_out_valid || i_out_ready;
    // Decrypting drops every x; the second letter stays on the square read port.
    assign drop_p = (r_dir == pfc_pkg::DIR_DEC) && (r_p == pfc_pkg::LTR_X);
    assign drop_q = (r_dir == pfc_pkg::DIR_DEC) && (sq_rdata == pfc_pkg::LTR_X);

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_fill      = r_fill;
        n_key_done  = r_key_done;
        n_pend      = r_pend;
        n_pend_v    = r_pend_v;
        n_walk      = r_walk;
        n_a         = r_a;
        n_b         = r_b;
        n_a2        = r_a2;
        n_more      = r_more;
        n_ia        = r_ia;
        n_na        = r_na;
        n_nb        = r_nb;
        n_p         = r_p;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        o_in_ready  = 1'b0;
        sq_we       = 1'b0;
        pos_we      = 1'b0;
        sq_re       = 1'b0;
        pos_re      = 1'b0;
        sq_raddr    = r_na;
        pos_raddr   = r_a;

        case (r_state)
            pfc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in.mode == pfc_pkg::MODE_KEY) begin
                        if (r_key_done) begin
                            n_key_done = 1'b0;
                            n_pend_v   = 1'b0;
                            n_pend     = '0;
                        end
                        n_used = used_eff;
                        n_fill = fill_eff;
                        if (place_ok) begin
                            sq_we             = 1'b1;
                            pos_we            = 1'b1;
                            n_used[place_ltr] = 1'b1;
                            n_fill            = fill_eff + 5'd1;
                        end
                        if (i_in.last) begin
                            n_walk  = '0;
                            n_state = pfc_pkg::S_FILL;
                        end
                    end else if (r_key_done) begin
                        n_pend   = pend_mid;
                        n_pend_v = pend_v_mid && !i_in.last;
                        if (has_pair) begin
                            n_a     = r_pend;
                            n_b     = pair_b;
                            n_more  = tail;
                            n_a2    = pend_mid;
                            n_state = pfc_pkg::S_POS_A;
                        end else if (tail) begin
                            n_a     = pend_mid;
                            n_b     = pfc_pkg::LTR_X;
                            n_more  = 1'b0;
                            n_state = pfc_pkg::S_POS_A;
                        end
                    end
                end
            end

            pfc_pkg::S_FILL: begin
                if (place_ok) begin
                    sq_we             = 1'b1;
                    pos_we            = 1'b1;
                    n_used[place_ltr] = 1'b1;
                    n_fill            = r_fill + 5'd1;
                end
                n_walk = r_walk + 5'd1;
                if (r_walk == pfc_pkg::LTR_Z) begin
                    n_key_done = 1'b1;
                    n_state    = pfc_pkg::S_IDLE;
                end
            end

            pfc_pkg::S_POS_A: begin
                pos_re    = 1'b1;
                pos_raddr = r_a;
                n_state   = pfc_pkg::S_POS_B;
            end

            pfc_pkg::S_POS_B: begin
                pos_re    = 1'b1;
                pos_raddr = r_b;
                n_ia      = pos_rdata;
                n_state   = pfc_pkg::S_CALC;
            end

            pfc_pkg::S_CALC: begin
                n_na    = calc_na;
                n_nb    = calc_nb;
                n_state = pfc_pkg::S_SQ_A;
            end

            pfc_pkg::S_SQ_A: begin
                sq_re    = 1'b1;
                sq_raddr = r_na;
                n_state  = pfc_pkg::S_SQ_B;
            end

            pfc_pkg::S_SQ_B: begin
                sq_re    = 1'b1;
                sq_raddr = r_nb;
                n_p      = sq_rdata;
                n_state  = pfc_pkg::S_EMIT_P;
            end

            pfc_pkg::S_EMIT_P: begin
                if (drop_p) begin
                    n_state = pfc_pkg::S_EMIT_Q;
                end else if (slot_free) begin
                    n_out_valid       = 1'b1;
                    n_out.out_letter  = r_p;
                    n_out.last_of_run = !r_more && drop_q;
                    n_state           = pfc_pkg::S_EMIT_Q;
                end
            end

            pfc_pkg::S_EMIT_Q: begin
                if (drop_q || slot_free) begin
                    if (!drop_q) begin
                        n_out_valid       = 1'b1;
                        n_out.out_letter  = sq_rdata;
                        n_out.last_of_run = !r_more;
                    end
                    if (r_more) begin
                        // advance to the padded tail pair
                        n_a     = r_a2;
                        n_b     = pfc_pkg::LTR_X;
                        n_more  = 1'b0;
                        n_state = pfc_pkg::S_POS_A;
                    end else begin
                        n_state = pfc_pkg::S_IDLE;
                    end
                end
            end

            default: begin
                n_state = pfc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pfc_pkg::S_IDLE;
            r_used      <= '0;
            r_fill      <= '0;
            r_key_done  <= 1'b0;
            r_pend      <= '0;
            r_pend_v    <= 1'b0;
            r_dir       <= pfc_pkg::DIR_ENC;
            r_walk      <= '0;
            r_more      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_fill      <= n_fill;
            r_key_done  <= n_key_done;
            r_pend      <= n_pend;
            r_pend_v    <= n_pend_v;
            r_walk      <= n_walk;
            r_more      <= n_more;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_dir <= i_cfg_wdata;
            end
        end
    end

    // payload registers: no reset
    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_a2  <= n_a2;
        r_ia  <= n_ia;
        r_na  <= n_na;
        r_nb  <= n_nb;
        r_p   <= n_p;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> sv/pfc_checker.sv
// Port-level checker for the Playfair cipher engine, bound to the top level.
// Depends on pfc_pkg and playfair_cipher_engine.
module pfc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input pfc_pkg::t_in_item  i_in,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input pfc_pkg::t_out_item o_out,
    input logic               i_cfg_we,
    input logic               i_cfg_wdata
);

    logic r_dir;

    // shadow the direction register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= pfc_pkg::DIR_ENC;
        end else if (i_cfg_we) begin
            r_dir <= i_cfg_wdata;
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // results are always letters
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.out_letter <= pfc_pkg::LTR_Z)
        else $error("result letter out of range");

    // decrypted output never carries x
    a_dec_no_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_dir == pfc_pkg::DIR_DEC |-> o_out.out_letter != pfc_pkg::LTR_X)
        else $error("x passed through decryption");

    // a key letter transaction yields no result
    a_key_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in.mode == pfc_pkg::MODE_KEY
        && (!o_out_valid || i_out_ready) |=> !o_out_valid)
        else $error("result after key letter");

    // after reset: ready, nothing pending
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready && !o_out_valid)
        else $error("bad state after reset");

endmodule

bind playfair_cipher_engine pfc_checker u_pfc_checker (.*);

>>> verif/tb_playfair_cipher_engine.sv
// Self-checking testbench for the Playfair cipher engine: a table of directed
// transactions, then random keys and messages under three idling phases.
// Depends on pfc_pkg and the playfair_cipher_engine RTL.
module tb_playfair_cipher_engine;

    timeunit 1ns;
    timeprecision 1ps;

    import pfc_pkg::*;

    localparam int SIDE          = 5;
    localparam int SETTLE_CYCLES = 40;     // key walk plus a pair, with margin
    localparam int HOLD_CYCLES   = 300;    // long receiver hold-off in the full-rate phase
    localparam int CYCLE_LIMIT   = 200000;

    localparam logic [LTR_W-1:0]     NO_LTR = 5'd31;   // index outside the alphabet
    localparam logic [0:3][LTR_W-1:0] NO_OUT = '0;

    typedef enum logic [1:0] {PH_RX_SLOW, PH_TX_SLOW, PH_FULL_RATE} t_phase;
    typedef enum logic {ROW_ITEM, ROW_DIR} t_row_kind;

    // One row of the directed table. Rows marked typed carry their expected letters;
    // the others are checked against the predictor.
    typedef struct {
        t_row_kind               kind;
        logic                    dir;
        logic                    mode;
        logic [LTR_W-1:0]        letter;
        logic                    last;
        bit                      typed;
        int                      n_out;
        logic [0:3][LTR_W-1:0]   ltrs;
    } t_stim_row;

    // Letters: a=0 b=1 c=2 e=4 f=5 h=7 l=11 n=13 o=14 p=15 v=21 y=24 z=25.
    // With an empty key the square is the alphabet without j, row by row.
    t_stim_row dir_table [27] = '{
        // a message letter before any key: dropped
        '{ROW_ITEM, DIR_ENC, MODE_MSG, 5'd0,   1'b0, 1'b1, 0, NO_OUT},
        // empty key, out-of-range letter with last: alphabet square
        '{ROW_ITEM, DIR_ENC, MODE_KEY, NO_LTR, 1'b1, 1'b1, 0, NO_OUT},
        // a,b same row: shift right
        '{ROW_ITEM, DIR_ENC, MODE_MSG, 5'd0,   1'b0, 1'b1, 0, NO_OUT},
        '{ROW_ITEM, DIR_ENC, MODE_MSG, 5'd1,   1'b0, 1'b1, 2, {5'd1, 5'd2, 5'd0, 5'd0}},
        // odd tail z padded with x, wrapping round the row
        '{ROW_ITEM, DIR_ENC, MODE_MSG, LTR_Z,  1'b1, 1'b1, 2, {5'd21, 5'd24, 5'd0, 5'd0}},
        // doubled l: l,x enciphered, second l stays held
        '{ROW_ITEM, DIR_ENC, MODE_MSG, 5'd11,  1'b0, 1'b1, 0, NO_OUT},
        '{ROW_ITEM, DIR_ENC, MODE_MSG, 5'd11,  1'b0, 1'b1, 2, {5'd13, 5'd21, 5'd0, 5'd0}},
        // message j read as i, rectangle rule
        '{ROW_ITEM, DIR_ENC, MODE_MSG, LTR_J,  1'b0, 1'b1, 2, {5'd14, 5'd5, 5'd0, 5'd0}},
        // a,v same column: shift down, wrapping
        '{ROW_ITEM, DIR_ENC, MODE_MSG, 5'd0,   1'b0, 1'b1, 0, NO_OUT},
        '{ROW_ITEM, DIR_ENC, MODE_MSG, 5'd21,  1'b0, 1'b1, 2, {5'd5, 5'd0, 5'd0, 5'd0}},
        // ignored letter whose last mark still pads the held z
        '{ROW_ITEM, DIR_ENC, MODE_MSG, LTR_Z,  1'b0, 1'b1, 0, NO_OUT},
        '{ROW_ITEM, DIR_ENC, MODE_MSG, NO_LTR, 1'b1, 1'b1, 2, {5'd21, 5'd24, 5'd0, 5'd0}},
        '{ROW_DIR,  DIR_DEC, MODE_MSG, 5'd0,   1'b0, 1'b0, 0, NO_OUT},
        // b,c decrypt: shift left
        '{ROW_ITEM, DIR_ENC, MODE_MSG, 5'd1,   1'b0, 1'b1, 0, NO_OUT},
        '{ROW_ITEM, DIR_ENC, MODE_MSG, 5'd2,   1'b0, 1'b1, 2, {5'd0, 5'd1, 5'd0, 5'd0}},
        // y,z decrypt gives x,y: the x is dropped
        '{ROW_ITEM, DIR_ENC, MODE_MSG, 5'd24,  1'b0, 1'b1, 0, NO_OUT},
        '{ROW_ITEM, DIR_ENC, MODE_MSG, LTR_Z,  1'b0, 1'b1, 1, {5'd24, 5'd0, 5'd0, 5'd0}},
        // odd tail when decrypting: dropped
        '{ROW_ITEM, DIR_ENC, MODE_MSG, 5'd0,   1'b1, 1'b1, 0, NO_OUT},
        // doubled a when decrypting: a plain pair, wrapping left
        '{ROW_ITEM, DIR_ENC, MODE_MSG, 5'd0,   1'b0, 1'b1, 0, NO_OUT},
        '{ROW_ITEM, DIR_ENC, MODE_MSG, 5'd0,   1'b0, 1'b1, 2, {5'd4, 5'd4, 5'd0, 5'd0}},
        '{ROW_DIR,  DIR_ENC, MODE_MSG, 5'd0,   1'b0, 1'b0, 0, NO_OUT},
        // new key over a complete one: p, j skipped, p repeated, z last
        '{ROW_ITEM, DIR_ENC, MODE_KEY, 5'd15,  1'b0, 1'b0, 0, NO_OUT},
        '{ROW_ITEM, DIR_ENC, MODE_KEY, LTR_J,  1'b0, 1'b0, 0, NO_OUT},
        '{ROW_ITEM, DIR_ENC, MODE_KEY, 5'd15,  1'b0, 1'b0, 0, NO_OUT},
        '{ROW_ITEM, DIR_ENC, MODE_KEY, LTR_Z,  1'b1, 1'b0, 0, NO_OUT},
        '{ROW_ITEM, DIR_ENC, MODE_MSG, 5'd7,   1'b0, 1'b0, 0, NO_OUT},
        '{ROW_ITEM, DIR_ENC, MODE_MSG, LTR_X,  1'b1, 1'b0, 0, NO_OUT}
    };

    // ------------------------------------------------------------------
    // Clock, DUT ports and DUT
    // ------------------------------------------------------------------
    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in        = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out;
    logic      i_cfg_we    = 1'b0;
    logic      i_cfg_wdata = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    playfair_cipher_engine DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Predictor state: the square, letter positions and the held letter
    // ------------------------------------------------------------------
    logic [LTR_W-1:0] sq_letter [NUM_CELLS];
    logic [LTR_W-1:0] ltr_pos   [NUM_LTRS];
    bit               ltr_seen  [NUM_LTRS];
    int               sq_fill     = 0;
    bit               key_ready   = 1'b0;
    logic [LTR_W-1:0] held_letter = '0;
    bit               held_valid  = 1'b0;
    logic             cipher_dir  = DIR_ENC;

    t_out_item cipher_out_q [$];   // enciphered/deciphered letters still to arrive
    int        error_count = 0;
    int        sent_items  = 0;
    int        cycle_count = 0;
    t_phase    phase       = PH_RX_SLOW;

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        error_count++;
    endtask

    task automatic place_letter(input logic [LTR_W-1:0] l);
        if (sq_fill < NUM_CELLS) begin
            sq_letter[sq_fill] = l;
            ltr_pos[l]         = 5'(sq_fill);
            sq_fill++;
        end
        ltr_seen[l] = 1'b1;
    endtask

    // Cipher one pair and append its letters; when decrypting, drop any x.
    task automatic cipher_pair(input logic [LTR_W-1:0] a, input logic [LTR_W-1:0] b,
                               inout t_out_item run [$]);
        int ra, ca, rb, cb, shift, swap;
        logic [LTR_W-1:0] p, q;
        ra    = int'(ltr_pos[a]) / SIDE;
        ca    = int'(ltr_pos[a]) % SIDE;
        rb    = int'(ltr_pos[b]) / SIDE;
        cb    = int'(ltr_pos[b]) % SIDE;
        shift = (cipher_dir == DIR_DEC) ? SIDE - 1 : 1;
        if (ra == rb) begin
            ca = (ca + shift) % SIDE;
            cb = (cb + shift) % SIDE;
        end else if (ca == cb) begin
            ra = (ra + shift) % SIDE;
            rb = (rb + shift) % SIDE;
        end else begin
            swap = ca;
            ca   = cb;
            cb   = swap;
        end
        p = sq_letter[ra * SIDE + ca];
        q = sq_letter[rb * SIDE + cb];
        if (cipher_dir == DIR_ENC || p != LTR_X) run.push_back(t_out_item'{p, 1'b0});
        if (cipher_dir == DIR_ENC || q != LTR_X) run.push_back(t_out_item'{q, 1'b0});
    endtask

    // Advance the predictor by one accepted transaction; return the letters it causes.
    task automatic playfair_step(input t_in_item it, output t_out_item run [$]);
        logic [LTR_W-1:0] l;
        bit               in_range;
        int               k;
        run      = {};
        l        = it.letter;
        in_range = (it.letter < NUM_LTRS);
        if (it.mode == MODE_KEY) begin
            // a key letter over a complete key starts afresh
            if (key_ready) begin
                foreach (ltr_seen[m]) ltr_seen[m] = 1'b0;
                sq_fill     = 0;
                key_ready   = 1'b0;
                held_valid  = 1'b0;
                held_letter = '0;
            end
            if (in_range && l != LTR_J && !ltr_seen[l]) place_letter(l);
            if (it.last) begin
                for (k = 0; k < NUM_LTRS; k++)
                    if (5'(k) != LTR_J && !ltr_seen[k]) place_letter(5'(k));
                key_ready = 1'b1;
            end
            return;
        end
        if (!key_ready) return;
        if (in_range && l == LTR_J) l = LTR_I;
        if (cipher_dir == DIR_ENC) begin
            if (in_range) begin
                if (!held_valid) begin
                    held_letter = l;
                    held_valid  = 1'b1;
                end else if (held_letter == l) begin
                    cipher_pair(l, LTR_X, run);
                end else begin
                    cipher_pair(held_letter, l, run);
                    held_valid = 1'b0;
                end
            end
            if (it.last && held_valid) begin
                cipher_pair(held_letter, LTR_X, run);
                held_valid = 1'b0;
            end
        end else begin
            if (in_range) begin
                if (!held_valid) begin
                    held_letter = l;
                    held_valid  = 1'b1;
                end else begin
                    cipher_pair(held_letter, l, run);
                    held_valid = 1'b0;
                end
            end
            if (it.last) held_valid = 1'b0;
        end
        if (run.size() > 0) run[run.size() - 1].last_of_run = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // Offer a transaction and hold it until the block takes it.
    task automatic offer_item(input t_in_item it);
        i_in       <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Idle the sender for a random gap, as the current phase asks.
    task automatic hold_source();
        int gap, pct;
        gap = 0;
        pct = (phase == PH_RX_SLOW) ? 36 : (phase == PH_TX_SLOW) ? 78 : 0;
        while ($urandom_range(99) < pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_predicted(input t_in_item it);
        t_out_item run [$];
        offer_item(it);
        playfair_step(it, run);
        foreach (run[k]) cipher_out_q.push_back(run[k]);
        hold_source();
    endtask

    // Drop valid, wait for every expected letter, then let the block finish any
    // work that causes no output (the key walk above all).
    task automatic drain_block();
        i_in_valid <= 1'b0;
        while (cipher_out_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_direction(input logic d);
        drain_block();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= d;
        cipher_dir   = d;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [LTR_W-1:0] any_letter();
        return ($urandom_range(7) == 0) ? 5'($urandom_range(31, 26)) : 5'($urandom_range(25, 0));
    endfunction

    // A key of random length; now and then message letters slip in before its
    // last letter and are dropped by the block.
    task automatic send_key();
        int len, k;
        len = $urandom_range(8, 1);
        for (k = 0; k < len; k++) begin
            if (k == len - 1 && len > 1 && $urandom_range(5) == 0)
                repeat ($urandom_range(2, 1))
                    send_predicted(t_in_item'{MODE_MSG, any_letter(), 1'b0});
            send_predicted(t_in_item'{MODE_KEY, any_letter(), k == len - 1});
            sent_items++;
        end
    endtask

    // A message with doubled letters, j, x and the odd stray last mark mixed in.
    task automatic send_message();
        int len, k, pick;
        logic [LTR_W-1:0] l, prev;
        len  = $urandom_range(12, 1);
        prev = 5'($urandom_range(25));
        for (k = 0; k < len; k++) begin
            pick = $urandom_range(19);
            if (pick < 3)       l = prev;
            else if (pick == 3) l = LTR_J;
            else if (pick == 4) l = LTR_X;
            else                l = any_letter();
            send_predicted(t_in_item'{MODE_MSG, l, (k == len - 1) || ($urandom_range(24) == 0)});
            sent_items++;
            if (l < NUM_LTRS) prev = l;
        end
    endtask

    task automatic run_random(input int n);
        int target;
        target = sent_items + n;
        while (sent_items < target) begin
            if ($urandom_range(4) == 0) send_key();
            send_message();
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls per phase, plus one long hold-off when the
    // full-rate phase opens so that the block backs up and stalls its input
    // ------------------------------------------------------------------
    int     hold_left  = 0;
    t_phase seen_phase = PH_RX_SLOW;

    always @(posedge i_clk) begin : sink
        int rx_pct;
        rx_pct     = (phase == PH_RX_SLOW) ? 78 : (phase == PH_TX_SLOW) ? 36 : 0;
        seen_phase <= phase;
        if (phase == PH_FULL_RATE && seen_phase != PH_FULL_RATE) begin
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_pct);
        end
    end

    // Compare every accepted output with the oldest expected letter.
    always @(posedge i_clk) begin : out_check
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (cipher_out_q.size() == 0) begin
                report_mismatch($sformatf("unexpected letter %0d", o_out.out_letter));
            end else begin
                want = cipher_out_q.pop_front();
                if (o_out.out_letter !== want.out_letter)
                    report_mismatch($sformatf("out_letter %0d, expected %0d",
                                              o_out.out_letter, want.out_letter));
                if (o_out.last_of_run !== want.last_of_run)
                    report_mismatch($sformatf("last_of_run %0b, expected %0b",
                                              o_out.last_of_run, want.last_of_run));
            end
        end
    end

    // Abandon a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: reset, directed table, then three random phases
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_in_item  it;
        t_out_item run [$];
        int        k;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_table[r]) begin
            if (dir_table[r].kind == ROW_DIR) begin
                write_direction(dir_table[r].dir);
            end else begin
                it = '{dir_table[r].mode, dir_table[r].letter, dir_table[r].last};
                offer_item(it);
                // keep the predictor in step even where the row carries its own answer
                playfair_step(it, run);
                if (dir_table[r].typed) begin
                    for (k = 0; k < dir_table[r].n_out; k++)
                        cipher_out_q.push_back(t_out_item'{dir_table[r].ltrs[k],
                                                           k == dir_table[r].n_out - 1});
                end else begin
                    foreach (run[m]) cipher_out_q.push_back(run[m]);
                end
                hold_source();
            end
        end

        write_direction(DIR_DEC);
        run_random(70);
        write_direction(DIR_ENC);
        phase <= PH_TX_SLOW;
        run_random(70);
        write_direction(DIR_DEC);
        phase <= PH_FULL_RATE;
        run_random(80);

        drain_block();
        if (cipher_out_q.size() != 0)
            report_mismatch($sformatf("%0d letters never arrived", cipher_out_q.size()));
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
